### design/bdl_pkg.sv
// ----------------------------------------------------------------------------
// bdl_pkg
// shared codes, reset values and types for the button debounce block
// ----------------------------------------------------------------------------
package bdl_pkg;

    localparam int BUTTON_COUNT_DEFAULT = 3;
    localparam int PIN_COUNT            = 3;   // width of the pin and mask fields
    localparam int TIME_W               = 32;
    localparam int CFG_W                = 16;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    // event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PRESS   = 3'd1;
    localparam logic [2:0] EV_RELEASE = 3'd2;
    localparam logic [2:0] EV_LONG    = 3'd3;
    localparam logic [2:0] EV_REPEAT  = 3'd4;

    // register indexes
    localparam logic [1:0] CFG_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd2;
    localparam logic [1:0] CFG_REPEAT     = 2'd3;

    // reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] REPEAT_RESET     = 16'd200;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
        logic [CFG_W-1:0] repeat_period;
    } timing_cfg_t;

    // per-button control from the top level
    typedef struct packed {
        logic sample;   // sample item accepted while enabled
        logic take;     // take item accepted for this button
    } button_ctrl_t;

endpackage

### design/button_debounce_long_press_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// debouncer with press, release, long-press and auto-repeat events
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item. The result register is
// loaded at the accepting edge when it is free (else the skid entry is), so
// out_valid is registered. A new item can be taken every cycle while in_stall
// is low. A sample item (op 0) updates all buttons at once while enabled, in the
// per-button logic, which is only a few 32-bit subtractions and compares
// deep; a take item (op 1) returns and clears the latched event of one
// button. The result is held in an output register backed by one skid
// entry, so the input keeps flowing for one more item after the output
// stalls; in_stall rises only when both entries are full. Configuration writes
// should be done while no items are in flight.
module button_debounce_long_press_repeat
    import bdl_pkg::*;
#(
    parameter int BUTTON_COUNT = BUTTON_COUNT_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input items
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [PIN_COUNT-1:0] pin_levels,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic [1:0]           button_id,
    // result items
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           event_code,
    output logic [PIN_COUNT-1:0] pressed_mask,
    // configuration
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic        enabled_reg;
    timing_cfg_t timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg                <= 1'b0;
            timing_reg.debounce_time   <= DEBOUNCE_RESET;
            timing_reg.long_press_time <= LONG_PRESS_RESET;
            timing_reg.repeat_period   <= REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:     enabled_reg                <= cfg_data[0];
                CFG_DEBOUNCE:   timing_reg.debounce_time   <= cfg_data;
                CFG_LONG_PRESS: timing_reg.long_press_time <= cfg_data;
                CFG_REPEAT:     timing_reg.repeat_period   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // handshakes
    logic in_accept;
    logic out_take;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    // per-button logic
    logic [BUTTON_COUNT-1:0] level_next;
    logic [2:0]              button_event [BUTTON_COUNT];

    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_button
        button_ctrl_t ctrl;
        logic         pressed;

        // buttons past the pin field read as pressed
        if (i < PIN_COUNT)
        begin : g_pin
            assign pressed = !pin_levels[i];
        end
        else
        begin : g_nopin
            assign pressed = 1'b1;
        end

        assign ctrl.sample = in_accept && (op == OP_SAMPLE) && enabled_reg;
        assign ctrl.take   = in_accept && (op == OP_TAKE) && (int'(button_id) == i);

        bdl_button u_button (
            .clk           (clk),
            .rst_n         (rst_n),
            .cfg           (timing_reg),
            .ctrl          (ctrl),
            .pressed       (pressed),
            .now_ms        (now_ms),
            .level_next    (level_next[i]),
            .latched_event (button_event[i])
        );
    end

    // result of the item being accepted
    logic [2:0]           new_event;
    logic [PIN_COUNT-1:0] new_mask;

    always_comb
    begin
        new_event = EV_NONE;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            // out-of-range ids match no button and give none
            if ((op == OP_TAKE) && (int'(button_id) == i))
            begin
                new_event = button_event[i];
            end
        end
        new_mask = '0;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            if (i < BUTTON_COUNT)
            begin
                new_mask[i] = level_next[i];
            end
        end
    end

    // output register plus one skid entry
    logic                 out_valid_reg;
    logic [2:0]           out_event_reg;
    logic [PIN_COUNT-1:0] out_mask_reg;
    logic                 skid_valid_reg;
    logic [2:0]           skid_event_reg;
    logic [PIN_COUNT-1:0] skid_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            // output slot frees up: skid entry first, else the new item
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_event_reg <= skid_event_reg;
                out_mask_reg  <= skid_mask_reg;
            end
            else
            begin
                out_event_reg <= new_event;
                out_mask_reg  <= new_mask;
            end
        end
        else if (in_accept)
        begin
            skid_event_reg <= new_event;
            skid_mask_reg  <= new_mask;
        end
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign event_code   = out_event_reg;
    assign pressed_mask = out_mask_reg;

    // skid entry only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // a waiting result is never dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg)
        else $error("stalled result lost");

    // after an accepted item the output register always holds a result
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule

### design/bdl_button.sv
// ----------------------------------------------------------------------------
// bdl_button
// state and next-state logic of one debounced button
// ----------------------------------------------------------------------------
module bdl_button
    import bdl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  timing_cfg_t       cfg,
    input  button_ctrl_t      ctrl,
    input  logic              pressed,
    input  logic [TIME_W-1:0] now_ms,
    output logic              level_next,
    output logic [2:0]        latched_event
);

    logic              level_reg;
    logic [TIME_W-1:0] agree_time_reg;
    logic [TIME_W-1:0] press_start_reg;
    logic              long_done_reg;
    logic [TIME_W-1:0] repeat_time_reg;
    logic [2:0]        event_reg;

    logic [TIME_W-1:0] agree_time_next;
    logic [TIME_W-1:0] press_start_next;
    logic              long_done_next;
    logic [TIME_W-1:0] repeat_time_next;
    logic [2:0]        event_next;

    logic              change_ok;
    logic              press_now;
    logic              sample_level;
    logic [TIME_W-1:0] start_mux;
    logic              long_done_mux;
    logic [TIME_W-1:0] repeat_mux;
    logic [2:0]        event_mux;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_repeat;

    always_comb
    begin
        change_ok = (pressed != level_reg) &&
                    ((now_ms - agree_time_reg) >= {16'd0, cfg.debounce_time});
        sample_level = change_ok ? pressed : level_reg;
        press_now    = change_ok && pressed;

        start_mux     = press_now ? now_ms : press_start_reg;
        long_done_mux = press_now ? 1'b0 : long_done_reg;
        repeat_mux    = press_now ? now_ms : repeat_time_reg;
        event_mux     = event_reg;
        if (press_now)
        begin
            event_mux = EV_PRESS;
        end
        else if (change_ok)
        begin
            event_mux = EV_RELEASE;
        end

        held         = now_ms - start_mux;
        since_repeat = now_ms - repeat_mux;

        agree_time_next  = agree_time_reg;
        press_start_next = press_start_reg;
        long_done_next   = long_done_reg;
        repeat_time_next = repeat_time_reg;
        event_next       = event_reg;
        level_next       = level_reg;

        if (ctrl.sample)
        begin
            level_next       = sample_level;
            // agree time follows now unless a disagreeing level is still pending
            agree_time_next  = ((pressed == level_reg) || change_ok) ? now_ms : agree_time_reg;
            press_start_next = start_mux;
            long_done_next   = long_done_mux;
            repeat_time_next = repeat_mux;
            event_next       = event_mux;
            if (sample_level)
            begin
                if (!long_done_mux && (held >= {16'd0, cfg.long_press_time}))
                begin
                    event_next       = EV_LONG;
                    long_done_next   = 1'b1;
                    repeat_time_next = now_ms;
                end
                else if (long_done_mux && (since_repeat >= {16'd0, cfg.repeat_period}))
                begin
                    event_next       = EV_REPEAT;
                    repeat_time_next = now_ms;
                end
            end
        end
        else if (ctrl.take)
        begin
            event_next = EV_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 1'b0;
            agree_time_reg  <= '0;
            press_start_reg <= '0;
            long_done_reg   <= 1'b0;
            repeat_time_reg <= '0;
            event_reg       <= EV_NONE;
        end
        else
        begin
            level_reg       <= level_next;
            agree_time_reg  <= agree_time_next;
            press_start_reg <= press_start_next;
            long_done_reg   <= long_done_next;
            repeat_time_reg <= repeat_time_next;
            event_reg       <= event_next;
        end
    end

    assign latched_event = event_reg;

endmodule
